// ===== rtl/asct_pkg.sv =====
// ----------------------------------------------------------------------------
// asct_pkg
// Shared types, codes and the arctangent table for the arc sector tessellator.
// ----------------------------------------------------------------------------
`default_nettype none
package asct_pkg;

	localparam int unsigned ARC_CAP  = 60;
	localparam int unsigned TAB_LEN  = 24;
	localparam int unsigned CW       = 34;	// CORDIC datapath width
	localparam logic [1:0]  KIND_ARC    = 2'd0;
	localparam logic [1:0]  KIND_CENTER = 2'd1;
	localparam logic [1:0]  KIND_EMPTY  = 2'd2;
	localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

	// one vertex command from the front to the back
	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic [30:0]        radius;
		logic [15:0]        angle;
		logic [1:0]         kind;
		logic               last;
	} cmd_t;

	// one finished vertex
	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic               is_center;
		logic               empty_res;
		logic               last;
	} res_t;

	// atan(2^-i) in 2^32 units per turn
	function automatic logic [29:0] atan_val(input logic [4:0] i);
		logic [29:0] v;
		case (i)
			5'd0:  v = 30'd536870912;
			5'd1:  v = 30'd316933406;
			5'd2:  v = 30'd167458907;
			5'd3:  v = 30'd85004756;
			5'd4:  v = 30'd42667331;
			5'd5:  v = 30'd21354465;
			5'd6:  v = 30'd10679838;
			5'd7:  v = 30'd5340245;
			5'd8:  v = 30'd2670163;
			5'd9:  v = 30'd1335087;
			5'd10: v = 30'd667544;
			5'd11: v = 30'd333772;
			5'd12: v = 30'd166886;
			5'd13: v = 30'd83443;
			5'd14: v = 30'd41722;
			5'd15: v = 30'd20861;
			5'd16: v = 30'd10430;
			5'd17: v = 30'd5215;
			5'd18: v = 30'd2608;
			5'd19: v = 30'd1304;
			5'd20: v = 30'd652;
			5'd21: v = 30'd326;
			5'd22: v = 30'd163;
			5'd23: v = 30'd81;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/asct_fifo.sv =====
// ----------------------------------------------------------------------------
// asct_fifo
// Small register queue of any depth, head shown combinationally.
// ----------------------------------------------------------------------------
`default_nettype none
module asct_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] wdata,
	output logic              full,
	input  wire logic         pop,
	output logic [W-1:0]      rdata,
	output logic              empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			if (do_pop)  rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= wdata;
	end
endmodule
`default_nettype wire

// ===== rtl/asct_front.sv =====
// ----------------------------------------------------------------------------
// asct_front
// Takes a request, sizes the ring, divides the sweep once (not for radius 0)
// and issues one vertex command per beat into the queue while it has room.
// ----------------------------------------------------------------------------
`default_nettype none
module asct_front #(
	parameter int SEGMENTS = 60
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire logic signed [31:0] center_x,
	input  wire logic signed [31:0] center_y,
	input  wire logic [30:0]        radius,
	input  wire logic [15:0]        start_angle,
	input  wire logic [16:0]        stop_angle,
	output logic                    full,
	output asct_pkg::cmd_t          cmd,
	output logic                    cmd_push,
	input  wire logic               cmd_full
);
	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_CNT  = 2'd1;
	localparam logic [1:0] F_DIV  = 2'd2;
	localparam logic [1:0] F_EMIT = 2'd3;
	localparam logic [5:0] SEG    = 6'(SEGMENTS);

	logic [1:0]         state_q;
	logic signed [31:0] cx_q, cy_q;
	logic [30:0]        r_q;
	logic [15:0]        start_q;
	logic [16:0]        sweep_q;
	logic               circle_q, zero_q;
	logic [5:0]         n_q, rem_q, accr_q;
	logic [16:0]        dvd_q, acc_q;
	logic [4:0]         cnt_q;
	logic [6:0]         idx_q, lastidx_q;

	logic [22:0] prod;
	logic [6:0]  nraw;
	logic [5:0]  nclamp;
	logic [6:0]  shifted;
	logic        ge;
	logic [6:0]  rsum;
	logic        rwrap;
	logic        is_last, adv;

	function automatic logic [16:0] sweep_now(input logic [16:0] sp, input logic [15:0] st);
		return sp - {1'b0, st};
	endfunction

	assign full = (state_q != F_IDLE);

	// ring size of a sector: ceil(SEGMENTS*sweep/turn), kept in [2, cap]
	always_comb begin
		prod = SEG * {7'd0, sweep_q[15:0]} + 23'd65535;
		nraw = prod[22:16];
		if (nraw < 7'd2) nclamp = 6'd2;
		else if (nraw > 7'(asct_pkg::ARC_CAP)) nclamp = 6'(asct_pkg::ARC_CAP);
		else nclamp = nraw[5:0];
	end

	// restoring divider step
	assign shifted = {rem_q, dvd_q[16]};
	assign ge      = (shifted >= {1'b0, n_q});

	// running remainder of sweep*i + n/2 over n
	assign rsum  = {1'b0, accr_q} + {1'b0, rem_q};
	assign rwrap = (rsum >= {1'b0, n_q});

	always_comb begin
		cmd.cx     = cx_q;
		cmd.cy     = cy_q;
		cmd.radius = r_q;
		cmd.angle  = '0;
		cmd.kind   = asct_pkg::KIND_ARC;
		cmd.last   = 1'b0;
		is_last    = (idx_q == lastidx_q);
		adv        = 1'b0;
		if (zero_q) begin
			cmd.kind = asct_pkg::KIND_EMPTY;
			cmd.last = 1'b1;
			is_last  = 1'b1;
		end else if (circle_q) begin
			cmd.last  = is_last;
			cmd.angle = is_last ? 16'd0 : acc_q[15:0];
			adv       = !is_last;
		end else if (idx_q == 7'd0 || is_last) begin
			cmd.kind = asct_pkg::KIND_CENTER;
			cmd.last = is_last;
		end else begin
			cmd.angle = start_q + acc_q[15:0];
			adv       = 1'b1;
		end
	end

	assign cmd_push = (state_q == F_EMIT) && !cmd_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= F_IDLE;
			idx_q     <= '0;
			cnt_q     <= '0;
			zero_q    <= 1'b0;
			circle_q  <= 1'b0;
			sweep_q   <= '0;
			n_q       <= '0;
			rem_q     <= '0;
			dvd_q     <= '0;
			acc_q     <= '0;
			accr_q    <= '0;
			lastidx_q <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (push) begin
						zero_q   <= (radius == '0);
						circle_q <= sweep_now(stop_angle, start_angle) >= 17'h10000;
						sweep_q  <= sweep_now(stop_angle, start_angle);
						idx_q    <= '0;
						state_q  <= (radius == '0) ? F_EMIT : F_CNT;
					end
				end
				F_CNT: begin
					n_q       <= circle_q ? SEG : nclamp;
					dvd_q     <= circle_q ? 17'h10000 : sweep_q;
					lastidx_q <= circle_q ? {1'b0, SEG} : {1'b0, nclamp} + 7'd2;
					rem_q     <= '0;
					cnt_q     <= '0;
					state_q   <= F_DIV;
				end
				F_DIV: begin
					rem_q <= ge ? 6'(shifted - {1'b0, n_q}) : shifted[5:0];
					dvd_q <= {dvd_q[15:0], ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'd16) begin
						acc_q   <= '0;
						accr_q  <= n_q >> 1;
						state_q <= F_EMIT;
					end
				end
				F_EMIT: begin
					if (!cmd_full) begin
						idx_q <= idx_q + 1'b1;
						if (adv) begin
							accr_q <= rwrap ? 6'(rsum - {1'b0, n_q}) : rsum[5:0];
							acc_q  <= acc_q + dvd_q + {16'd0, rwrap};
						end
						if (is_last) state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && push) begin
			cx_q    <= center_x;
			cy_q    <= center_y;
			r_q     <= radius;
			start_q <= start_angle;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/asct_back.sv =====
// ----------------------------------------------------------------------------
// asct_back
// Executes vertex commands (arc ones via iterative CORDIC, radius scaling,
// centre offset with saturation), then one beat into the result queue.
// ----------------------------------------------------------------------------
`default_nettype none
module asct_back #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire asct_pkg::cmd_t cmd,
	input  wire logic           cmd_empty,
	output logic                cmd_pop,
	output asct_pkg::res_t      res,
	output logic                res_push,
	input  wire logic           res_full
);
	localparam int NSTEPS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_ROT  = 3'd1;
	localparam logic [2:0] B_MUL  = 3'd2;
	localparam logic [2:0] B_FIN  = 3'd3;
	localparam logic [2:0] B_OUT  = 3'd4;
	localparam int CW = asct_pkg::CW;

	logic [2:0]            state_q;
	asct_pkg::cmd_t        cmd_q;
	logic signed [CW-1:0]  x_q, y_q, z_q;
	logic                  neg_q;
	logic [4:0]            step_q;
	logic signed [63:0]    px_s2, py_s2;
	asct_pkg::res_t        res_q;

	logic signed [CW-1:0]  z0, zf, at;
	logic                  nf;
	logic signed [31:0]    csx, csy;
	logic signed [CW-1:0]  xn, yn;

	// centre + round(p / 2^30), saturated to 32 bits
	function automatic logic signed [31:0] place(input logic signed [31:0] c,
		input logic signed [63:0] p);
		logic signed [63:0] v;
		logic signed [31:0] o;
		v = 64'(c) + ((p + 64'sd536870912) >>> 30);
		if (v > 64'sd2147483647) o = 32'sh7FFFFFFF;
		else if (v < -64'sd2147483648) o = 32'sh80000000;
		else o = v[31:0];
		return o;
	endfunction

	// fold the angle into the right half plane
	always_comb begin
		z0 = CW'($signed({cmd.angle, 16'd0}));
		zf = z0;
		nf = 1'b0;
		if (z0 > 34'sd1073741824) begin
			zf = z0 - 34'sd2147483648;
			nf = 1'b1;
		end else if (z0 < -34'sd1073741824) begin
			zf = z0 + 34'sd2147483648;
			nf = 1'b1;
		end
	end

	assign at = $signed({4'd0, asct_pkg::atan_val(step_q)});
	assign csx = neg_q ? 32'(-x_q) : 32'(x_q);
	assign csy = neg_q ? 32'(-y_q) : 32'(y_q);

	always_comb begin
		if (z_q >= 0) begin
			xn = x_q - (y_q >>> step_q);
			yn = y_q + (x_q >>> step_q);
		end else begin
			xn = x_q + (y_q >>> step_q);
			yn = y_q - (x_q >>> step_q);
		end
	end

	assign cmd_pop  = (state_q == B_IDLE) && !cmd_empty;
	assign res_push = (state_q == B_OUT) && !res_full;
	assign res      = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				B_IDLE: if (!cmd_empty)
					state_q <= (cmd.kind == asct_pkg::KIND_ARC) ? B_ROT : B_OUT;
				B_ROT: begin
					step_q <= step_q + 1'b1;
					if (step_q == 5'(NSTEPS-1)) state_q <= B_MUL;
				end
				B_MUL:   state_q <= B_FIN;
				B_FIN:   state_q <= B_OUT;
				B_OUT:   if (!res_full) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
			if (state_q == B_IDLE) step_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				cmd_q <= cmd;
				x_q   <= asct_pkg::CORDIC_X0;
				y_q   <= '0;
				z_q   <= zf;
				neg_q <= nf;
				res_q.is_center <= (cmd.kind == asct_pkg::KIND_CENTER);
				res_q.empty_res <= (cmd.kind == asct_pkg::KIND_EMPTY);
				res_q.last      <= cmd.last;
				res_q.point_x   <= (cmd.kind == asct_pkg::KIND_CENTER) ? cmd.cx : '0;
				res_q.point_y   <= (cmd.kind == asct_pkg::KIND_CENTER) ? cmd.cy : '0;
			end
			B_ROT: begin
				x_q <= xn;
				y_q <= yn;
				z_q <= (z_q >= 0) ? z_q - at : z_q + at;
			end
			B_MUL: begin
				px_s2 <= $signed({1'b0, cmd_q.radius}) * csx;
				py_s2 <= $signed({1'b0, cmd_q.radius}) * csy;
			end
			B_FIN: begin
				res_q.point_x <= place(cmd_q.cx, px_s2);
				res_q.point_y <= place(cmd_q.cy, py_s2);
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/arc_sector_tessellator_unit.sv =====
// ----------------------------------------------------------------------------
// arc_sector_tessellator_unit
// A request runs through the front (ring sizing, sweep division, command
// issue), the command queue, the back (iterative CORDIC with CORDIC_STEPS
// capped at 24, radius scaling, centre offset) and the result queue to the
// ports; a centre or empty vertex skips the CORDIC loop. The back takes the
// next command only once the last result is queued. The front stays busy
// for a request until its last vertex command is queued. Reset (arst_n low)
// empties both queues and idles front and back at once.
// ----------------------------------------------------------------------------
`default_nettype none
module arc_sector_tessellator_unit #(
	parameter int SEGMENTS     = 60,
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic signed [31:0] center_x,
	input  wire logic signed [31:0] center_y,
	input  wire logic [30:0]        radius,
	input  wire logic [15:0]        start_angle,
	input  wire logic [16:0]        stop_angle,
	output logic                    empty,
	input  wire logic               pop,
	output logic signed [31:0]      point_x,
	output logic signed [31:0]      point_y,
	output logic                    is_center,
	output logic                    empty_res,
	output logic                    last
);
	localparam int CMD_W = $bits(asct_pkg::cmd_t);
	localparam int RES_W = $bits(asct_pkg::res_t);

	asct_pkg::cmd_t cmd_in, cmd_out;
	asct_pkg::res_t res_in, res_out;
	logic           cmd_push, cmd_full, cmd_pop, cmd_empty;
	logic           res_push, res_full;

	// front: request intake, ring sizing, angle stepping
	asct_front #(.SEGMENTS(SEGMENTS)) u_front (
		.clk, .arst_n, .push,
		.center_x, .center_y, .radius, .start_angle, .stop_angle,
		.full,
		.cmd(cmd_in), .cmd_push, .cmd_full
	);

	// decoupling queue of vertex commands
	asct_fifo #(.W(CMD_W), .DEPTH(4)) u_cmdq (
		.clk, .arst_n,
		.push(cmd_push), .wdata(cmd_in), .full(cmd_full),
		.pop(cmd_pop), .rdata(cmd_out), .empty(cmd_empty)
	);

	// back: CORDIC and coordinate math
	asct_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
		.clk, .arst_n,
		.cmd(cmd_out), .cmd_empty, .cmd_pop,
		.res(res_in), .res_push, .res_full
	);

	// result queue, head drives the output ports
	asct_fifo #(.W(RES_W), .DEPTH(2)) u_resq (
		.clk, .arst_n,
		.push(res_push), .wdata(res_in), .full(res_full),
		.pop, .rdata(res_out), .empty
	);

	assign point_x   = res_out.point_x;
	assign point_y   = res_out.point_y;
	assign is_center = res_out.is_center;
	assign empty_res = res_out.empty_res;
	assign last      = res_out.last;
endmodule
`default_nettype wire
